@@ rtl/core/hcd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package hcd_pkg;

   // result kinds
   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE   = 3'd0;
   localparam logic [2:0] ERR_LINE   = 3'd1;
   localparam logic [2:0] ERR_OVER   = 3'd2;
   localparam logic [2:0] ERR_CRLF   = 3'd3;
   localparam logic [2:0] ERR_CANCEL = 3'd4;

   // width of the byte total field on the result channel
   localparam int PAYLOAD_TOTAL_W = 48;

   // characters of interest
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_F  = 8'h66;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;
   localparam logic [7:0] CHAR_LO_X  = 8'h78;
   localparam logic [7:0] CHAR_UP_X  = 8'h58;

   // prefix tracking codes
   localparam logic [1:0] PFX_NONE = 2'd0;
   localparam logic [1:0] PFX_ZERO = 2'd1;
   localparam logic [1:0] PFX_0X   = 2'd2;
   localparam logic [1:0] PFX_PAST = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       cancel;
   } req_item_type;

   typedef struct packed {
      logic [1:0]                 out_kind;
      logic [7:0]                 out_byte;
      logic [2:0]                 error_code;
      logic [PAYLOAD_TOTAL_W-1:0] payload_total;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ rtl/core/http_chunked_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Chunked transfer body decoder: takes one raw body byte per item and returns
// each payload byte, an end item carrying the payload byte total, or an error
// item. Every accepted item is decoded in the cycle it is accepted and any
// result lands in the output register, or in the skid register while the
// output is stalled, so the block sustains one item per clock while req_stall
// is low. The skid register absorbs one result when rsp_stall is high;
// req_stall is raised only while that skid register is full, so input stalls
// follow output stalls. After an end or an error item every further input is
// accepted and dropped until reset. The chunk size is parsed in SIZE_BITS bits
// and the payload count saturates at TOTAL_BITS bits.
module http_chunked_decoder #(
   parameter int SIZE_BITS  = 32,
   parameter int TOTAL_BITS = 48
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  hcd_pkg::req_item_type req_item,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output hcd_pkg::rsp_item_type rsp_item
);
   import hcd_pkg::*;

   localparam logic [2:0] PH_LINE    = 3'd0;
   localparam logic [2:0] PH_LINE_CR = 3'd1;
   localparam logic [2:0] PH_EXT     = 3'd2;
   localparam logic [2:0] PH_EXT_CR  = 3'd3;
   localparam logic [2:0] PH_DATA    = 3'd4;
   localparam logic [2:0] PH_WANT_CR = 3'd5;
   localparam logic [2:0] PH_WANT_LF = 3'd6;
   localparam logic [2:0] PH_DONE    = 3'd7;

   typedef struct packed {
      logic [SIZE_BITS-1:0] accum;
      logic                 digits;
      logic                 trail;
      logic [1:0]           prefix;
   } line_type;

   typedef struct packed {
      line_type   line;
      logic [2:0] err;
      logic       to_ext;
   } line_res_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) ||
             (c == CHAR_LF) || (c == CHAR_VT) || (c == CHAR_FF);
   endfunction

   // hex digit value, bit 4 set when the character is a digit
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         r = {1'b1, 4'(c - CHAR_ZERO)};
      end else if (c >= CHAR_LO_A && c <= CHAR_LO_F) begin
         r = {1'b1, 4'(c - CHAR_LO_A + 8'd10)};
      end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
         r = {1'b1, 4'(c - CHAR_UP_A + 8'd10)};
      end
      return r;
   endfunction

   // one character of size text
   function automatic line_res_type line_char(input line_type st, input logic [7:0] c);
      line_res_type r;
      logic [4:0]   h;
      r        = '0;
      r.line   = st;
      r.err    = ERR_NONE;
      r.to_ext = 1'b0;
      h        = hex_digit(c);
      if (is_space(c)) begin
         if (st.prefix != PFX_NONE) begin
            r.line.trail = 1'b1;
         end
      end else if (st.trail) begin
         r.err = ERR_LINE;
      end else if (c == CHAR_SEMI) begin
         if (!st.digits) begin
            r.err = ERR_LINE;
         end else begin
            r.to_ext = 1'b1;
         end
      end else if ((c == CHAR_LO_X || c == CHAR_UP_X) && st.prefix == PFX_ZERO) begin
         r.line.prefix = PFX_0X;
         r.line.digits = 1'b0;
      end else if (!h[4]) begin
         r.err = ERR_LINE;
      end else begin
         r.line.prefix = (st.prefix == PFX_NONE && c == CHAR_ZERO) ? PFX_ZERO : PFX_PAST;
         if (|st.accum[SIZE_BITS-1 -: 4]) begin
            r.err = ERR_OVER;
         end else begin
            r.line.accum  = {st.accum[SIZE_BITS-5:0], h[3:0]};
            r.line.digits = 1'b1;
         end
      end
      return r;
   endfunction

   logic [2:0]            phase_ff, phase_in;
   line_type              line_ff, line_in, line_v;
   line_res_type          lr;
   logic [SIZE_BITS-1:0]  left_ff, left_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic [TOTAL_BITS+PAYLOAD_TOTAL_W-1:0] total_ext;
   logic                  do_end;
   logic                  res_valid;
   rsp_item_type          res;
   logic [7:0]            c;
   logic                  req_fire;
   logic                  rsp_take;
   logic                  out_valid_ff, skid_valid_ff;
   rsp_item_type          out_ff, skid_ff;

   assign c         = req_item.data_byte;
   assign req_stall = skid_valid_ff;
   assign req_fire  = req_valid && !skid_valid_ff;
   assign rsp_take  = out_valid_ff && !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;
   assign total_ext = {{PAYLOAD_TOTAL_W{1'b0}}, total_in};

   // decode of one byte
   always_comb begin
      phase_in          = phase_ff;
      line_in           = line_ff;
      line_v            = line_ff;
      left_in           = left_ff;
      total_in          = total_ff;
      lr                = '0;
      do_end            = 1'b0;
      res_valid         = 1'b0;
      res.out_kind      = KIND_BYTE;
      res.out_byte      = 8'd0;
      res.error_code    = ERR_NONE;
      if (phase_ff != PH_DONE) begin
         if (req_item.cancel) begin
            res_valid      = 1'b1;
            res.out_kind   = KIND_ERR;
            res.error_code = ERR_CANCEL;
         end else begin
            unique case (phase_ff) inside
               PH_LINE, PH_LINE_CR: begin
                  if (phase_ff == PH_LINE_CR && c == CHAR_LF) begin
                     do_end = 1'b1;
                  end else begin
                     // a lone CR inside the size text counts as whitespace
                     if (phase_ff == PH_LINE_CR && line_ff.prefix != PFX_NONE) begin
                        line_v.trail = 1'b1;
                     end
                     if (c == CHAR_CR) begin
                        phase_in = PH_LINE_CR;
                        line_in  = line_v;
                     end else begin
                        lr       = line_char(line_v, c);
                        line_in  = lr.line;
                        phase_in = lr.to_ext ? PH_EXT : PH_LINE;
                        if (lr.err != ERR_NONE) begin
                           res_valid      = 1'b1;
                           res.out_kind   = KIND_ERR;
                           res.error_code = lr.err;
                        end
                     end
                  end
               end
               PH_EXT, PH_EXT_CR: begin
                  if (phase_ff == PH_EXT_CR && c == CHAR_LF) begin
                     do_end = 1'b1;
                  end else begin
                     phase_in = (c == CHAR_CR) ? PH_EXT_CR : PH_EXT;
                  end
               end
               PH_DATA: begin
                  if (total_ff != {TOTAL_BITS{1'b1}}) begin
                     total_in = total_ff + 1'b1;
                  end
                  left_in = left_ff - 1'b1;
                  if (left_ff == SIZE_BITS'(1)) begin
                     phase_in = PH_WANT_CR;
                  end
                  res_valid    = 1'b1;
                  res.out_byte = c;
               end
               PH_WANT_CR: begin
                  if (c != CHAR_CR) begin
                     res_valid      = 1'b1;
                     res.out_kind   = KIND_ERR;
                     res.error_code = ERR_CRLF;
                  end else begin
                     phase_in = PH_WANT_LF;
                  end
               end
               PH_WANT_LF: begin
                  if (c != CHAR_LF) begin
                     res_valid      = 1'b1;
                     res.out_kind   = KIND_ERR;
                     res.error_code = ERR_CRLF;
                  end else begin
                     line_in  = '0;
                     phase_in = PH_LINE;
                  end
               end
               default: begin
                  phase_in = PH_DONE;
               end
            endcase
            // end of a size line
            if (do_end) begin
               if (!line_ff.digits) begin
                  res_valid      = 1'b1;
                  res.out_kind   = KIND_ERR;
                  res.error_code = ERR_LINE;
               end else if (line_ff.accum == '0) begin
                  res_valid    = 1'b1;
                  res.out_kind = KIND_END;
               end else begin
                  left_in  = line_ff.accum;
                  line_in  = '0;
                  phase_in = PH_DATA;
               end
            end
         end
      end
      res.payload_total = total_ext[PAYLOAD_TOTAL_W-1:0];
      if (res_valid && res.out_kind != KIND_BYTE) begin
         phase_in = PH_DONE;
      end
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LINE;
         line_ff  <= '0;
         left_ff  <= '0;
         total_ff <= '0;
      end else if (req_fire) begin
         phase_ff <= phase_in;
         line_ff  <= line_in;
         left_ff  <= left_in;
         total_ff <= total_in;
      end
   end

   // output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_fire && res_valid) begin
         if (!out_valid_ff || rsp_take) begin
            out_ff       <= res;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= res;
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_ff <= 1'b0;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/hcd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hcd_checker (
   input wire                   clock,
   input wire                   reset,
   input wire                   req_stall,
   input wire                   rsp_valid,
   input wire                   rsp_stall,
   input hcd_pkg::rsp_item_type rsp_item
);
   import hcd_pkg::*;

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result item changed while stalled");

   // end or error item is the last one
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_item.out_kind != KIND_BYTE |=> !rsp_valid)
      else $error("result item after end or error");

   // payload byte carries no error and counts itself
   a_byte_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.out_kind == KIND_BYTE |->
         rsp_item.error_code == ERR_NONE && rsp_item.payload_total != '0)
      else $error("bad payload byte item");

   // error item carries a code and no byte
   a_err_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.out_kind == KIND_ERR |->
         rsp_item.error_code != ERR_NONE && rsp_item.out_byte == 8'd0)
      else $error("bad error item");

   // nothing comes out and the input is not stalled right after reset
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && !req_stall)
      else $error("output not empty after reset");

endmodule

bind http_chunked_decoder hcd_checker u_hcd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

`default_nettype wire

@@ tb/sv/tb_http_chunked_decoder.sv @@
`timescale 1ns / 1ps

module tb_http_chunked_decoder;
   import hcd_pkg::*;

   localparam int SIZE_BITS      = 32;
   localparam int TOTAL_BITS     = 48;
   localparam int BODY_ITEMS     = 1150;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 20;

   localparam logic [63:0] SIZE_MASK  = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - SIZE_BITS);
   localparam logic [63:0] TOTAL_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - TOTAL_BITS);

   typedef enum logic [3:0] {
      ST_LINE, ST_LINE_CR, ST_EXT, ST_EXT_CR, ST_DATA, ST_WANT_CR, ST_WANT_LF, ST_DONE
   } parse_state_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_item;

   http_chunked_decoder #(
      .SIZE_BITS  (SIZE_BITS),
      .TOTAL_BITS (TOTAL_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // decoder state as the testbench sees it
   parse_state_type st;
   logic [63:0]  size_acc;
   logic [63:0]  left_bytes;
   logic         seen_digit;
   logic         seen_trail;
   logic [1:0]   prefix_state;
   logic [63:0]  delivered_count;

   rsp_item_type pending_results[$];
   int           mismatch_count = 0;
   int           items_sent = 0;
   int           stall_cycles = 0;
   bit           burst_mode = 1'b0;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- decoder prediction

   function automatic bit is_ws(input logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF ||
             c == CHAR_VT || c == CHAR_FF;
   endfunction

   function automatic int hex_val(input logic [7:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
      if (c >= CHAR_LO_A && c <= CHAR_LO_F) return int'(c - CHAR_LO_A) + 10;
      if (c >= CHAR_UP_A && c <= CHAR_UP_F) return int'(c - CHAR_UP_A) + 10;
      return -1;
   endfunction

   function automatic void clear_size_line();
      size_acc     = '0;
      seen_digit   = 1'b0;
      seen_trail   = 1'b0;
      prefix_state = PFX_NONE;
   endfunction

   // builds a result; anything but a payload byte finishes the body
   function automatic rsp_item_type make_result(input logic [1:0] kind, input logic [7:0] b,
                                                input logic [2:0] err);
      rsp_item_type r;
      r.out_kind      = kind;
      r.out_byte      = b;
      r.error_code    = err;
      r.payload_total = delivered_count[PAYLOAD_TOTAL_W-1:0];
      if (kind != KIND_BYTE) st = ST_DONE;
      return r;
   endfunction

   // one character of chunk size text
   function automatic logic [2:0] line_char(input logic [7:0] c);
      int d;
      if (is_ws(c)) begin
         if (prefix_state != PFX_NONE) seen_trail = 1'b1;
         return ERR_NONE;
      end
      if (seen_trail) return ERR_LINE;
      if (c == CHAR_SEMI) begin
         if (!seen_digit) return ERR_LINE;
         st = ST_EXT;
         return ERR_NONE;
      end
      if ((c == CHAR_LO_X || c == CHAR_UP_X) && prefix_state == PFX_ZERO) begin
         prefix_state = PFX_0X;
         seen_digit   = 1'b0;
         return ERR_NONE;
      end
      d = hex_val(c);
      if (d < 0) return ERR_LINE;
      prefix_state = (prefix_state == PFX_NONE && c == CHAR_ZERO) ? PFX_ZERO : PFX_PAST;
      if (size_acc > (SIZE_MASK >> 4)) return ERR_OVER;
      size_acc   = (size_acc << 4) | 64'(d);
      seen_digit = 1'b1;
      return ERR_NONE;
   endfunction

   // CR LF closes the size line
   function automatic bit close_line(output rsp_item_type r);
      r = '0;
      if (!seen_digit) begin
         r = make_result(KIND_ERR, 8'h00, ERR_LINE);
         return 1'b1;
      end
      if (size_acc == 0) begin
         r = make_result(KIND_END, 8'h00, ERR_NONE);
         return 1'b1;
      end
      left_bytes = size_acc;
      clear_size_line();
      st = ST_DATA;
      return 1'b0;
   endfunction

   function automatic bit size_text(input logic [7:0] c, output rsp_item_type r);
      logic [2:0] err;
      r = '0;
      if (c == CHAR_CR) begin
         st = ST_LINE_CR;
         return 1'b0;
      end
      err = line_char(c);
      if (err != ERR_NONE) begin
         r = make_result(KIND_ERR, 8'h00, err);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // next decoder step; returns 1 when the item yields a result
   function automatic bit decode_byte(input logic [7:0] c, input logic cxl,
                                      output rsp_item_type r);
      r = '0;
      if (st == ST_DONE) return 1'b0;
      if (cxl) begin
         r = make_result(KIND_ERR, 8'h00, ERR_CANCEL);
         return 1'b1;
      end
      case (st)
         ST_LINE_CR: begin
            if (c == CHAR_LF) return close_line(r);
            st = ST_LINE;
            // the lone CR is whitespace, which never fails
            void'(line_char(CHAR_CR));
            return size_text(c, r);
         end
         ST_LINE: return size_text(c, r);
         ST_EXT_CR: begin
            if (c == CHAR_LF) return close_line(r);
            if (c == CHAR_CR) st = ST_EXT_CR;
            else st = ST_EXT;
         end
         ST_EXT: begin
            if (c == CHAR_CR) st = ST_EXT_CR;
         end
         ST_DATA: begin
            if (delivered_count < TOTAL_MASK) delivered_count = delivered_count + 1;
            left_bytes = left_bytes - 1;
            if (left_bytes == 0) st = ST_WANT_CR;
            r = make_result(KIND_BYTE, c, ERR_NONE);
            return 1'b1;
         end
         ST_WANT_CR: begin
            if (c != CHAR_CR) begin
               r = make_result(KIND_ERR, 8'h00, ERR_CRLF);
               return 1'b1;
            end
            st = ST_WANT_LF;
         end
         ST_WANT_LF: begin
            if (c != CHAR_LF) begin
               r = make_result(KIND_ERR, 8'h00, ERR_CRLF);
               return 1'b1;
            end
            clear_size_line();
            st = ST_LINE;
         end
         default: st = ST_DONE;
      endcase
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic int idle_len(input bit no_gaps);
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // send one item and record what it should produce
   task automatic send_item(input logic [7:0] b, input logic cxl);
      int           gap;
      rsp_item_type exp_r;
      gap = idle_len(burst_mode);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= {b, cxl};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (decode_byte(b, cxl, exp_r)) pending_results.push_back(exp_r);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   task automatic send_crlf();
      send_item(CHAR_CR, 1'b0);
      send_item(CHAR_LF, 1'b0);
   endtask

   // hold the sender off until every expected result is back
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // one whitespace item, or a lone CR followed by a space
   task automatic send_space();
      case ($urandom_range(0, 5))
         0: send_item(CHAR_SPACE, 1'b0);
         1: send_item(CHAR_TAB, 1'b0);
         2: send_item(CHAR_VT, 1'b0);
         3: send_item(CHAR_FF, 1'b0);
         4: send_item(CHAR_LF, 1'b0);
         default: begin
            send_item(CHAR_CR, 1'b0);
            send_item(CHAR_SPACE, 1'b0);
         end
      endcase
   endtask

   // well-formed size line with random decoration
   task automatic send_size_line(input int unsigned size);
      int          nd;
      logic [3:0]  nib;
      logic [7:0]  b;
      logic [7:0]  prev;
      nd = 1;
      while ((size >> (4 * nd)) != 0) nd++;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_space();
      if ($urandom_range(0, 3) == 0) send_text($urandom_range(0, 1) ? "0x" : "0X");
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) send_item(CHAR_ZERO, 1'b0);
      for (int i = nd - 1; i >= 0; i--) begin
         nib = 4'((size >> (4 * i)) & 15);
         if (nib < 10) b = CHAR_ZERO + 8'(nib);
         else b = ($urandom_range(0, 1) ? CHAR_UP_A : CHAR_LO_A) + 8'(nib - 10);
         send_item(b, 1'b0);
      end
      if ($urandom_range(0, 3) == 0) begin
         // extension: any bytes, but no CR LF before the real one
         send_item(CHAR_SEMI, 1'b0);
         prev = CHAR_SEMI;
         repeat ($urandom_range(0, 6)) begin
            b = 8'($urandom_range(0, 255));
            if (prev == CHAR_CR && b == CHAR_LF) b = CHAR_SPACE;
            send_item(b, 1'b0);
            prev = b;
         end
      end else if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) send_space();
      end
      send_crlf();
   endtask

   function automatic int unsigned pick_chunk_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(1, 8);
      if (r < 90) return $urandom_range(9, 40);
      return $urandom_range(41, 255);
   endfunction

   // ---------------------------------------------------------------- tests

   // extreme payload bytes, prefix, whitespace, leading zero and an extension with a lone CR
   task automatic test_directed_chunks();
      send_text("\t0X2 ");
      send_crlf();
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_crlf();
      send_text("01;");
      send_item(CHAR_CR, 1'b0);
      send_text("z");
      send_crlf();
      send_item(8'h80, 1'b0);
      send_crlf();
   endtask

   // long well-formed body with random chunks, one full drain on the way
   task automatic test_random_body();
      int unsigned size;
      bit          paused;
      paused = 1'b0;
      while (items_sent < BODY_ITEMS) begin
         burst_mode = ($urandom_range(0, 3) == 0);
         size = pick_chunk_size();
         send_size_line(size);
         repeat (size) send_item(8'($urandom_range(0, 255)), 1'b0);
         send_crlf();
         if (!paused && items_sent >= BODY_ITEMS / 2) begin
            wait_for_results();
            paused = 1'b1;
         end
      end
      burst_mode = 1'b0;
   endtask

   // the body ends once per run: a last chunk, a broken line, or a cancel
   task automatic test_body_end();
      case ($urandom_range(0, 10))
         0: begin send_text("0"); send_crlf(); end
         1: begin send_text("0x0;tail"); send_crlf(); end
         2: begin send_text(" 00 "); send_crlf(); end
         3: begin send_text("1g"); send_crlf(); end
         4: begin send_text("2 3"); send_crlf(); end
         5: send_crlf();
         6: begin send_text("100000000"); send_crlf(); end
         7: begin
            send_text("1");
            send_crlf();
            send_item(8'($urandom_range(0, 255)), 1'b0);
            send_item(CHAR_CR, 1'b0);
            send_text("z");
         end
         8: send_item(8'($urandom_range(0, 255)), 1'b1);
         9: begin send_text("0x"); send_crlf(); end
         default: begin send_text(";x"); send_crlf(); end
      endcase
   endtask

   // once finished, nothing comes out, cancel included
   task automatic test_ignored_after_finish();
      repeat (40) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   // ---------------------------------------------------------------- receiver stalls

   initial begin : rsp_stall_gen
      int r;
      int n;
      bit s;
      rsp_stall = 1'b0;
      forever begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            s = 1'b0;
            n = $urandom_range(1, 20);
         end else if (r < 50) begin
            s = 1'b0;
            n = $urandom_range(30, 80);
         end else if (r < 85) begin
            s = 1'b1;
            n = $urandom_range(1, 3);
         end else if (r < 97) begin
            s = 1'b1;
            n = $urandom_range(4, 12);
         end else begin
            s = 1'b1;
            n = $urandom_range(20, 60);
         end
         @(negedge clock);
         rsp_stall <= s;
         repeat (n - 1) @(negedge clock);
      end
   end

   // ---------------------------------------------------------------- result check

   always @(posedge clock) begin : check_results
      rsp_item_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result kind %0d byte %h code %0d total %0d", $time,
                     rsp_item.out_kind, rsp_item.out_byte, rsp_item.error_code,
                     rsp_item.payload_total);
            mismatch_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_item.out_kind !== exp_r.out_kind) begin
               $display("%0t: out_kind expected %0d actual %0d", $time, exp_r.out_kind,
                        rsp_item.out_kind);
               mismatch_count++;
            end
            if (rsp_item.out_byte !== exp_r.out_byte) begin
               $display("%0t: out_byte expected %h actual %h", $time, exp_r.out_byte,
                        rsp_item.out_byte);
               mismatch_count++;
            end
            if (rsp_item.error_code !== exp_r.error_code) begin
               $display("%0t: error_code expected %0d actual %0d", $time, exp_r.error_code,
                        rsp_item.error_code);
               mismatch_count++;
            end
            if (rsp_item.payload_total !== exp_r.payload_total) begin
               $display("%0t: payload_total expected %0d actual %0d", $time,
                        exp_r.payload_total, rsp_item.payload_total);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   initial begin : watchdog
      wait (stall_cycles >= WATCHDOG_LIMIT);
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("[http_chunked_decoder] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_item  = '0;
      st              = ST_LINE;
      left_bytes      = '0;
      delivered_count = '0;
      clear_size_line();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_chunks();
      wait_for_results();
      test_random_body();
      test_body_end();
      test_ignored_after_finish();

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[http_chunked_decoder] OK");
      end else begin
         $display("[http_chunked_decoder] ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/hcd_pkg.sv
rtl/core/http_chunked_decoder.sv
rtl/core/hcd_checker.sv
tb/sv/tb_http_chunked_decoder.sv
